// ----- rtl/core/zrbs_pkg.sv -----
// Shared constants, types and opcode decode for the relocation bitmap scanner.
package zrbs_pkg;

  localparam int unsigned CodeLenWidth  = 17;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned IndexWidth    = 13;
  localparam int unsigned CountWidth    = 15;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned MaxCodeBytes  = 65536;

  localparam logic [CodeLenWidth-1:0] MaxCodeLen = CodeLenWidth'(MaxCodeBytes);

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegCodeLength = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] RegScanEnable = CfgIdxWidth'(1);

  // Opcode constants
  localparam logic [7:0] OpJp       = 8'hC3;
  localparam logic [7:0] OpCall     = 8'hCD;
  localparam logic [7:0] CondMask   = 8'hC7;
  localparam logic [7:0] OpJpCond   = 8'hC2;
  localparam logic [7:0] OpCallCond = 8'hC4;
  localparam logic [7:0] LdRrMask   = 8'hCF;
  localparam logic [7:0] OpLdRr     = 8'h01;
  localparam logic [7:0] OpStA      = 8'h32;
  localparam logic [7:0] OpLdA      = 8'h3A;
  localparam logic [7:0] OpStHl     = 8'h22;
  localparam logic [7:0] OpLdHl     = 8'h2A;

  typedef enum logic [1:0] {
    PhOpcode = 2'd0,
    PhLow    = 2'd1,
    PhHigh   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ClsNone = 2'd0,
    ClsAddr = 2'd1,
    ClsLdRr = 2'd2
  } op_class_e;

  function automatic op_class_e opcode_class(input logic [7:0] op);
    op_class_e cls;
    cls = ClsNone;
    if (op == OpJp || op == OpCall) begin
      cls = ClsAddr;
    end else if ((op & CondMask) == OpJpCond || (op & CondMask) == OpCallCond) begin
      cls = ClsAddr;
    end else if ((op & LdRrMask) == OpLdRr) begin
      cls = ClsLdRr;
    end else if (op == OpStA || op == OpLdA || op == OpStHl || op == OpLdHl) begin
      cls = ClsAddr;
    end
    return cls;
  endfunction

endpackage

// ----- rtl/core/z80_relocation_bitmap_scanner.sv -----
// Top level of the 8080/Z80 relocation bitmap scanner.
// Path: a code byte waits in the input register; the decode and mark step then loads
//   its bitmap transaction from there into the result register.
// Throughput: one code byte per cycle unless a held bitmap transaction is not taken.
// Reset: asynchronous, active low; clears scan state, sets code_length to 0 and
//   scan_enable to 1. No clearing pass; the block accepts bytes right after reset.
module z80_relocation_bitmap_scanner #(
  parameter int unsigned MaxBytes = zrbs_pkg::MaxCodeBytes
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // code byte channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [zrbs_pkg::ByteWidth-1:0]      code_byte_i,
  // bitmap channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [zrbs_pkg::ByteWidth-1:0]      bitmap_byte_o,
  output logic [zrbs_pkg::IndexWidth-1:0]     bitmap_index_o,
  output logic                                last_o,
  output logic [zrbs_pkg::CountWidth-1:0]     mark_count_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [zrbs_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [zrbs_pkg::CodeLenWidth-1:0]   cfg_data_i
);
  import zrbs_pkg::*;

  localparam logic [CodeLenWidth-1:0] MaxLen = CodeLenWidth'(MaxBytes);

  // Configuration registers
  logic [CodeLenWidth-1:0] code_length_q;
  logic                    scan_enable_q;

  // Input register
  logic                 byte_valid_q;
  logic [ByteWidth-1:0] byte_q;

  // Scan state
  logic [CodeLenWidth-1:0] position_q, position_d;
  phase_e                  phase_q, phase_d;
  logic                    needs_nonzero_q, needs_nonzero_d;
  logic [ByteWidth-1:0]    operand_low_q, operand_low_d;
  logic [ByteWidth-1:0]    accum_q, accum_d;
  logic [CountWidth-1:0]   total_q, total_d;

  // Result register
  logic                  out_valid_q;
  logic [ByteWidth-1:0]  out_byte_q;
  logic [IndexWidth-1:0] out_index_q;
  logic                  out_last_q;
  logic [CountWidth-1:0] out_count_q;

  // Decode signals
  logic [CodeLenWidth-1:0] len_eff;
  logic                    advance;
  logic                    active;
  logic [CodeLenWidth:0]   pos_plus1;
  logic [CodeLenWidth:0]   pos_plus2;
  logic [ByteWidth*2-1:0]  operand;
  logic                    mark;
  logic [ByteWidth-1:0]    accum_marked;
  logic [CountWidth-1:0]   total_marked;
  logic                    is_last;
  logic                    emit;
  op_class_e               cls;

  // Move a byte out of the input register whenever the result slot is free or draining.
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !byte_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // Saturate oversized lengths.
  assign len_eff   = (code_length_q > MaxLen) ? MaxLen : code_length_q;
  assign active    = byte_valid_q && (position_q < len_eff);
  assign pos_plus1 = {1'b0, position_q} + (CodeLenWidth+1)'(1);
  assign pos_plus2 = {1'b0, position_q} + (CodeLenWidth+1)'(2);
  assign operand   = {byte_q, operand_low_q};
  assign cls       = opcode_class(byte_q);
  assign is_last   = (pos_plus1 == {1'b0, len_eff});

  // Mark a high operand byte if enabled and its address is in the image, nonzero for LD rr.
  assign mark = (phase_q == PhHigh) && scan_enable_q &&
                ({1'b0, operand} < len_eff) &&
                (!needs_nonzero_q || (operand != '0));

  always_comb begin
    accum_marked = accum_q;
    accum_marked[position_q[2:0]] = accum_q[position_q[2:0]] | mark;
  end

  assign total_marked = total_q + CountWidth'(mark);
  assign emit         = active && ((position_q[2:0] == 3'd7) || is_last);

  always_comb begin
    phase_d         = phase_q;
    needs_nonzero_d = needs_nonzero_q;
    operand_low_d   = operand_low_q;
    position_d      = position_q;
    accum_d         = accum_q;
    total_d         = total_q;
    if (advance && active) begin
      position_d = pos_plus1[CodeLenWidth-1:0];
      total_d    = total_marked;
      accum_d    = emit ? '0 : accum_marked;
      unique case (phase_q)
        PhLow: begin
          operand_low_d = byte_q;
          phase_d       = PhHigh;
        end
        PhHigh: begin
          phase_d         = PhOpcode;
          needs_nonzero_d = 1'b0;
        end
        default: begin
          // Opcode phase; also covers the unused phase code.
          phase_d = PhOpcode;
          if (cls != ClsNone && pos_plus2 < {1'b0, len_eff}) begin
            phase_d         = PhLow;
            needs_nonzero_d = (cls == ClsLdRr);
          end
        end
      endcase
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= '0;
      scan_enable_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegCodeLength) begin
        code_length_q <= cfg_data_i;
      end else if (cfg_index_i == RegScanEnable) begin
        scan_enable_q <= cfg_data_i[0];
      end
    end
  end

  // Input register: hold the byte until it can advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= code_byte_i;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q      <= '0;
      phase_q         <= PhOpcode;
      needs_nonzero_q <= 1'b0;
      operand_low_q   <= '0;
      accum_q         <= '0;
      total_q         <= '0;
    end else begin
      position_q      <= position_d;
      phase_q         <= phase_d;
      needs_nonzero_q <= needs_nonzero_d;
      operand_low_q   <= operand_low_d;
      accum_q         <= accum_d;
      total_q         <= total_d;
    end
  end

  // Result register: load a bitmap transaction, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_byte_q  <= accum_marked;
      out_index_q <= position_q[IndexWidth+2:3];
      out_last_q  <= is_last;
      out_count_q <= total_marked;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bitmap_byte_o  = out_byte_q;
  assign bitmap_index_o = out_index_q;
  assign last_o         = out_last_q;
  assign mark_count_o   = out_count_q;

endmodule
